[design/csdc_pkg.sv]
// ----------------------------------------------------------------------------
// csdc_pkg
// Shared types and constants of the clock synthesizer divider calculator.
// ----------------------------------------------------------------------------
package csdc_pkg;

    localparam int unsigned FOUT_W = 28;
    localparam int unsigned REF_W  = 26;
    localparam int unsigned VCO_W  = 30;

    localparam logic [FOUT_W-1:0] FOUT_MIN     = 28'd2500;
    localparam logic [FOUT_W-1:0] FOUT_MAX     = 28'd200000000;
    localparam logic [REF_W-1:0]  REF_MIN      = 26'd10000000;
    localparam logic [REF_W-1:0]  REF_MAX      = 26'd40000000;
    localparam logic [REF_W-1:0]  REF_RESET    = 26'd27000000;
    localparam logic [VCO_W-1:0]  VCO_MIN      = 30'd600000000;
    localparam logic [FOUT_W-1:0] RDIV_LIMIT   = 28'd292969;
    localparam logic [FOUT_W-1:0] DIVBY4_LIMIT = 28'd150000000;
    localparam logic [7:0]        DIVBY4_CODE  = 8'h0C;
    localparam logic [19:0]       P_OFFSET     = 20'd512;

    // divider width: dividends up to 64 bits
    localparam int unsigned DIV_W = 64;

    typedef struct packed {
        logic            start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

endpackage

[design/clock_synth_divider_calc_unit.sv]
// ----------------------------------------------------------------------------
// clock_synth_divider_calc_unit
// Divider settings of a fractional-N clock synthesizer from a wanted frequency.
// ----------------------------------------------------------------------------
// One frequency at a time: a beat is taken, the output divider and R divider
// are chosen, then the feedback ratio a + b/c is worked out with a shared
// bit-serial restoring divider (up to five divisions) and a bit-serial
// shift-add multiplier (one multiplier bit per cycle; the product for the
// output divider is redone each time that divider is raised). The result
// sits in an output register; the next item is taken once it has been read.
// ----------------------------------------------------------------------------
module clock_synth_divider_calc_unit
    import csdc_pkg::*;
#(
    parameter int unsigned DEN_BITS = 20
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [25:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [27:0] i_fout_hz,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_feedback_regs,
    output logic [63:0] o_output_regs,
    output logic [29:0] o_vco_freq_hz,
    output logic [11:0] o_out_divider,
    output logic [2:0]  o_r_div_log2,
    output logic [6:0]  o_pll_int_part,
    output logic [19:0] o_pll_frac_num,
    output logic [19:0] o_pll_frac_den
);

    localparam logic [DIV_W-1:0] DEN_MAX = DIV_W'((64'd1 << DEN_BITS) - 64'd1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RSCAN = 5'd1;
    localparam logic [4:0] S_DDIV  = 5'd2;
    localparam logic [4:0] S_DWAIT = 5'd3;
    localparam logic [4:0] S_VMUL  = 5'd4;
    localparam logic [4:0] S_VWAIT = 5'd5;
    localparam logic [4:0] S_DFIX  = 5'd6;
    localparam logic [4:0] S_ADIV  = 5'd7;
    localparam logic [4:0] S_AWAIT = 5'd8;
    localparam logic [4:0] S_BMUL  = 5'd9;
    localparam logic [4:0] S_BMW   = 5'd10;
    localparam logic [4:0] S_BDIV  = 5'd11;
    localparam logic [4:0] S_BDW   = 5'd12;
    localparam logic [4:0] S_CMUL  = 5'd13;
    localparam logic [4:0] S_CMW   = 5'd14;
    localparam logic [4:0] S_CDIV  = 5'd15;
    localparam logic [4:0] S_CDW   = 5'd16;
    localparam logic [4:0] S_QDIV  = 5'd17;
    localparam logic [4:0] S_QDW   = 5'd18;
    localparam logic [4:0] S_PMUL  = 5'd19;
    localparam logic [4:0] S_PMW   = 5'd20;
    localparam logic [4:0] S_DONE  = 5'd21;

    logic [4:0]       r_state;
    logic [25:0]      r_ref;
    logic [7:0]       r_r;
    logic [2:0]       r_rd;
    logic             r_divby4;
    logic [11:0]      r_d;
    logic [29:0]      r_fr;
    logic [29:0]      r_vco;
    logic [6:0]       r_a;
    logic [25:0]      r_rem;
    logic [19:0]      r_b;
    logic [19:0]      r_c;
    logic [DIV_W-1:0] r_q;
    logic             r_out_valid;

    t_div_req         w_req;
    t_div_rsp         w_rsp;
    logic             w_mstart;
    logic [DIV_W-1:0] w_ma;
    logic [31:0]      w_mb;
    logic             w_mdone;
    logic [DIV_W-1:0] w_mprod;

    logic [27:0]      w_fsat;
    logic [25:0]      w_refsat;
    logic [19:0]      w_p1;
    logic [19:0]      w_p2;
    logic [19:0]      w_m1;
    logic [DIV_W-1:0] w_b128;
    logic [DIV_W-1:0] w_cq;

    csdc_divider u_div (.i_clk, .i_rst_n, .i_req(w_req), .o_rsp(w_rsp));
    csdc_multiplier u_mul (
        .i_clk, .i_rst_n, .i_start(w_mstart), .i_a(w_ma), .i_b(w_mb),
        .o_done(w_mdone), .o_prod(w_mprod)
    );

    always_comb begin
        w_fsat = i_fout_hz;
        if (w_fsat < FOUT_MIN) w_fsat = FOUT_MIN;
        if (w_fsat > FOUT_MAX) w_fsat = FOUT_MAX;
        w_refsat = r_ref;
        if (w_refsat < REF_MIN) w_refsat = REF_MIN;
        if (w_refsat > REF_MAX) w_refsat = REF_MAX;
    end

    assign w_b128 = {37'd0, r_b, 7'd0};
    assign w_cq   = w_mprod;
    assign w_p1   = 20'({r_a, 7'd0}) + 20'(r_q) - P_OFFSET;
    assign w_p2   = 20'(w_b128 - w_cq);
    assign w_m1   = 20'({r_d, 7'd0}) - P_OFFSET;

    // shared-unit requests
    always_comb begin
        w_req.start = 1'b0;
        w_req.num   = '0;
        w_req.den   = '0;
        w_mstart    = 1'b0;
        w_ma        = '0;
        w_mb        = '0;
        unique case (r_state)
            S_DDIV: begin
                w_req.start = 1'b1;
                w_req.num   = DIV_W'(VCO_MIN);
                w_req.den   = DIV_W'(r_fr);
            end
            S_VMUL: begin
                w_mstart = 1'b1;
                w_ma     = DIV_W'(r_fr);
                w_mb     = 32'(r_d);
            end
            S_ADIV: begin
                w_req.start = 1'b1;
                w_req.num   = DIV_W'(r_vco);
                w_req.den   = DIV_W'(w_refsat);
            end
            S_BMUL: begin
                w_mstart = 1'b1;
                w_ma     = DIV_W'(r_rem);
                w_mb     = 32'(DEN_MAX);
            end
            S_BDIV: begin
                w_req.start = 1'b1;
                w_req.num   = r_q;
                w_req.den   = DIV_W'(w_refsat);
            end
            S_CMUL: begin
                w_mstart = 1'b1;
                w_ma     = {r_q[DIV_W-2:0], 1'b0};
                w_mb     = 32'(w_refsat);
            end
            S_CDIV: begin
                w_req.start = 1'b1;
                w_req.num   = r_q + DIV_W'(r_rem);
                w_req.den   = DIV_W'({r_rem, 1'b0});
            end
            S_QDIV: begin
                w_req.start = 1'b1;
                w_req.num   = w_b128;
                w_req.den   = DIV_W'(r_c);
            end
            S_PMUL: begin
                w_mstart = 1'b1;
                w_ma     = DIV_W'(r_c);
                w_mb     = 32'(r_q);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ref       <= REF_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_ref <= i_cfg_data;
            if (o_valid && i_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_r      <= 8'd1;
                        r_rd     <= '0;
                        r_divby4 <= (w_fsat > DIVBY4_LIMIT);
                        r_d      <= 12'd4;
                        r_fr     <= 30'(w_fsat);
                        if (w_fsat > DIVBY4_LIMIT) begin
                            r_state  <= S_VMUL;
                        end else if (w_fsat < RDIV_LIMIT) begin
                            r_state <= S_RSCAN;
                        end else begin
                            r_state <= S_DDIV;
                        end
                    end
                end
                S_RSCAN: begin
                    // r_fr holds r*f while doubling
                    if (r_r < 8'd128 && r_fr < 30'(RDIV_LIMIT)) begin
                        r_r  <= {r_r[6:0], 1'b0};
                        r_rd <= r_rd + 3'd1;
                        r_fr <= {r_fr[28:0], 1'b0};
                    end else begin
                        r_state <= S_DDIV;
                    end
                end
                S_DDIV: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (w_rsp.done) begin
                        if (r_r == 8'd1 && w_rsp.quo < 64'd6) r_d <= 12'd6;
                        else if (w_rsp.quo[0]) r_d <= 12'(w_rsp.quo + 64'd1);
                        else r_d <= 12'(w_rsp.quo);
                        r_state <= S_VMUL;
                    end
                end
                S_VMUL: r_state <= S_VWAIT;
                S_VWAIT: begin
                    if (w_mdone) begin
                        if (!r_divby4 && w_mprod < DIV_W'(VCO_MIN)) begin
                            r_d     <= r_d + 12'd2;
                            r_state <= S_DFIX;
                        end else begin
                            r_vco   <= 30'(w_mprod);
                            r_state <= S_ADIV;
                        end
                    end
                end
                S_DFIX: r_state <= S_VMUL;
                S_ADIV: r_state <= S_AWAIT;
                S_AWAIT: begin
                    if (w_rsp.done) begin
                        r_a     <= 7'(w_rsp.quo);
                        r_rem   <= 26'(w_rsp.rem);
                        r_state <= S_BMUL;
                    end
                end
                S_BMUL: r_state <= S_BMW;
                S_BMW: begin
                    if (w_mdone) begin
                        r_q     <= w_mprod;
                        r_state <= S_BDIV;
                    end
                end
                S_BDIV: r_state <= S_BDW;
                S_BDW: begin
                    if (w_rsp.done) begin
                        r_b <= 20'(w_rsp.quo);
                        if (w_rsp.quo == '0) begin
                            r_c     <= 20'(DEN_MAX);
                            r_state <= S_QDIV;
                        end else begin
                            r_q     <= w_rsp.quo;
                            r_state <= S_CMUL;
                        end
                    end
                end
                S_CMUL: r_state <= S_CMW;
                S_CMW: begin
                    if (w_mdone) begin
                        r_q     <= w_mprod;
                        r_state <= S_CDIV;
                    end
                end
                S_CDIV: r_state <= S_CDW;
                S_CDW: begin
                    if (w_rsp.done) begin
                        if (w_rsp.quo > DEN_MAX) r_c <= 20'(DEN_MAX);
                        else if (w_rsp.quo == '0) r_c <= 20'd1;
                        else r_c <= 20'(w_rsp.quo);
                        r_state <= S_QDIV;
                    end
                end
                S_QDIV: r_state <= S_QDW;
                S_QDW: begin
                    if (w_rsp.done) begin
                        r_q     <= w_rsp.quo;
                        r_state <= S_PMUL;
                    end
                end
                S_PMUL: r_state <= S_PMW;
                S_PMW: begin
                    if (w_mdone) begin
                        o_feedback_regs <= {r_c[15:8], r_c[7:0], 6'd0, w_p1[17:16],
                                            w_p1[15:8], w_p1[7:0], r_c[19:16],
                                            w_p2[19:16], w_p2[15:8], w_p2[7:0]};
                        // divide-by-4 code sits in bits 3:2 of the third byte
                        o_output_regs   <= {8'd0, 8'd1, 1'b0, r_rd, {2{r_divby4}},
                                            w_m1[17:16], w_m1[15:8],
                                            w_m1[7:0], 24'd0};
                        o_vco_freq_hz   <= r_vco;
                        o_out_divider   <= r_d;
                        o_r_div_log2    <= r_rd;
                        o_pll_int_part  <= r_a;
                        o_pll_frac_num  <= r_b;
                        o_pll_frac_den  <= r_c;
                        r_out_valid     <= 1'b1;
                        r_state         <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE) && !r_out_valid;
    assign o_valid     = r_out_valid;
    assign o_cfg_ready = (r_state == S_IDLE);

endmodule

[design/csdc_divider.sv]
// ----------------------------------------------------------------------------
// csdc_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module csdc_divider
    import csdc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_W-1:0]   r_quo, n_quo;
    logic [DIV_W-1:0]   r_rem, n_rem;
    logic [DIV_W-1:0]   r_den, n_den;
    logic [6:0]         r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [DIV_W:0]     w_trial;
    logic [DIV_W:0]     w_diff;

    always_comb begin
        w_trial = {r_rem, r_quo[DIV_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_den   = r_den;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
            n_cnt  = 7'(DIV_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[DIV_W]) begin
                n_rem = w_diff[DIV_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[DIV_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

[design/csdc_multiplier.sv]
// ----------------------------------------------------------------------------
// csdc_multiplier
// Shift-add multiplier, one multiplier bit per cycle, 64-bit product.
// ----------------------------------------------------------------------------
module csdc_multiplier
    import csdc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_a,
    input  logic [31:0]      i_b,
    output logic             o_done,
    output logic [DIV_W-1:0] o_prod
);

    logic [DIV_W-1:0] r_acc, n_acc;
    logic [DIV_W-1:0] r_a, n_a;
    logic [31:0]      r_b, n_b;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    always_comb begin
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_acc  = '0;
            n_a    = i_a;
            n_b    = i_b;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) n_acc = r_acc + r_a;
            n_a = {r_a[DIV_W-2:0], 1'b0};
            n_b = {1'b0, r_b[31:1]};
            if (r_b[31:1] == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
